/* hdl/lap5_pkg.sv */
// ----------------------------------------------------------------------------
// lap5_pkg: shared types and constants
// Word formats, item type codes and register indexes for the five-point
// Laplacian stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lap5_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LAP_BITS    = SAMPLE_BITS + 3;
  localparam int ROWIDX_W    = 10;
  localparam int COLIDX_W    = 10;
  localparam int TYPE_W      = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int SIZE_RESET  = 1024;

  // req_type codes
  localparam logic [TYPE_W-1:0] REQ_TOP   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_MID   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_LEFT  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RIGHT = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_BOT   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [TYPE_W-1:0]             req_type;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } lap5_in_t;

  typedef struct packed {
    logic signed [LAP_BITS-1:0] lap_value;
    logic [ROWIDX_W-1:0]        out_row;
    logic [COLIDX_W-1:0]        out_col;
    logic                       last_of_grid;
  } lap5_out_t;

  // one column of the line stores: row above and center row
  typedef struct packed {
    sample_t above;
    sample_t center;
  } lap5_pair_t;

  // the five taps of one cell plus its tag
  typedef struct packed {
    sample_t             up;
    sample_t             below;
    sample_t             left;
    sample_t             right;
    sample_t             center;
    logic [ROWIDX_W-1:0] row;
    logic [COLIDX_W-1:0] col;
    logic                last;
  } lap5_opnd_t;

  typedef struct packed {
    logic s1_valid;
    logic can_take;
  } lap5_pipe_st_t;

endpackage

/* hdl/lap5_line.sv */
// ----------------------------------------------------------------------------
// lap5_line: line store
// Above and center rows kept side by side, one write and one registered
// read per cycle, with write-to-read bypass on an address match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap5_line #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  lap5_pkg::lap5_pair_t     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output lap5_pkg::lap5_pair_t     rd_data
);
  import lap5_pkg::*;

  lap5_pair_t mem [DEPTH];
  lap5_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/lap5_cell.sv */
// ----------------------------------------------------------------------------
// lap5_cell: window cell
// Holds one column (above, center) of the stencil window and takes its
// neighbor's column when the window moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap5_cell (
  input  logic                 clk,
  input  logic                 load,
  input  lap5_pkg::lap5_pair_t d_in,
  output lap5_pkg::lap5_pair_t q
);
  import lap5_pkg::*;

  lap5_pair_t q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

/* hdl/lap5_sum.sv */
// ----------------------------------------------------------------------------
// lap5_sum: stencil adder and output register
// Pair sums in the first stage, final sum minus four times center in the
// second, which is also the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap5_sum (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    issue,
  input  lap5_pkg::lap5_opnd_t    opnd,
  input  logic                    out_stall,
  output logic                    out_valid,
  output lap5_pkg::lap5_out_t     out_data,
  output lap5_pkg::lap5_pipe_st_t st
);
  import lap5_pkg::*;

  localparam int SW = SAMPLE_BITS + 1;

  logic                       s1_v_r, s1_v_nxt;
  logic signed [SW-1:0]       s1_ub_r, s1_lr_r;
  sample_t                    s1_ctr_r;
  logic [ROWIDX_W-1:0]        s1_row_r;
  logic [COLIDX_W-1:0]        s1_col_r;
  logic                       s1_last_r;
  logic                       out_v_r, out_v_nxt;
  lap5_out_t                  out_r;

  logic                       out_take, s1_move;
  logic signed [SW-1:0]       ub_sum, lr_sum;
  logic signed [LAP_BITS-1:0] lap;

  always_comb begin
    out_take  = !out_v_r || !out_stall;
    s1_move   = s1_v_r && out_take;
    ub_sum    = SW'(opnd.up) + SW'(opnd.below);
    lr_sum    = SW'(opnd.left) + SW'(opnd.right);
    lap       = LAP_BITS'(s1_ub_r) + LAP_BITS'(s1_lr_r) - (LAP_BITS'(s1_ctr_r) <<< 2);
    s1_v_nxt  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    out_v_nxt = s1_move ? 1'b1 : (out_take ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ub_r   <= ub_sum;
      s1_lr_r   <= lr_sum;
      s1_ctr_r  <= opnd.center;
      s1_row_r  <= opnd.row;
      s1_col_r  <= opnd.col;
      s1_last_r <= opnd.last;
    end
    if (s1_move) begin
      out_r.lap_value    <= lap;
      out_r.out_row      <= s1_row_r;
      out_r.out_col      <= s1_col_r;
      out_r.last_of_grid <= s1_last_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_data    = out_r;
  assign st.s1_valid = s1_v_r;
  assign st.can_take = !s1_v_r || out_take;

endmodule

/* hdl/laplace_5point_stencil.sv */
// ----------------------------------------------------------------------------
// laplace_5point_stencil: streaming five-point Laplacian
// Takes one word per clock unless stalled: the top boundary row, then per
// interior row its left edge, grid_cols samples and right edge, then the
// bottom boundary row. Words whose type does not fit the expected
// position are dropped. The result for cell (i,j), up + down + left +
// right - 4*center, exact and 19 bits signed, leaves via the pair-sum and
// output registers once the word below it (sample (i+1,j) or bottom
// boundary j) is taken. The rate is set by the single-write, single-read
// line store that holds the above and center rows side by side; a
// three-column window (line store read register, center cell, left cell)
// slides one column per sample. After every configuration write the input
// is held off while the window reloads from the line store at the current
// column. There is no clearing pass after reset. Sizes below 2 act as 2,
// sizes above MAX_COLS / MAX_ROWS act as the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplace_5point_stencil #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lap5_pkg::lap5_in_t                    in_data,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lap5_pkg::lap5_out_t                   out_data,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lap5_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lap5_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lap5_pkg::*;

  localparam int AW  = $clog2(MAX_COLS);      // column address
  localparam int CW  = $clog2(MAX_COLS + 1);  // column count / size
  localparam int CW1 = CW + 1;
  localparam int RW  = $clog2(MAX_ROWS + 1);  // row count / size
  localparam int RST_COLS = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;
  localparam int RST_ROWS = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;

  typedef enum logic [2:0] {PH_TOP, PH_LEFT, PH_MID, PH_RIGHT, PH_BOT} phase_t;
  typedef enum logic [1:0] {ST_RUN, ST_FETCH0, ST_FETCH1} fetch_t;

  // control state
  phase_t          phase_r, phase_nxt;
  fetch_t          fst_r, fst_nxt;
  logic [AW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   cols_r, cols_nxt;
  logic [RW-1:0]   rows_r, rows_nxt;

  // edge values: left/right of the pending row, left of the incoming row
  sample_t         edge0_r, edge0_nxt;
  sample_t         edge1_r, edge1_nxt;
  sample_t         edge2_r, edge2_nxt;

  logic            in_acc, hit, samp, emit, cfg_wr;
  logic [TYPE_W-1:0] typ;
  sample_t         smp;
  logic [CW-1:0]   c_inc;
  logic [CW:0]     c_plus2;
  logic            c_end, c_wrap;
  logic [RW-1:0]   row_inc;
  logic [31:0]     cfg_val32;
  logic [CW-1:0]   cols_clamp;
  logic [RW-1:0]   rows_clamp;

  // window
  logic            rd_en, w0_load;
  logic [AW-1:0]   rd_addr;
  lap5_pair_t      wr_pair, w_right, w_ctr, w_left;
  lap5_opnd_t      opnd;
  lap5_pipe_st_t   pst;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = !pst.can_take || (fst_r != ST_RUN);
  assign in_acc    = in_valid && !in_stall;
  assign typ       = in_data.req_type;
  assign smp       = in_data.sample_value;

  // column bookkeeping
  always_comb begin
    c_inc   = CW'(col_r) + CW'(1);
    c_plus2 = CW1'(col_r) + CW1'(2);
    c_end   = (c_inc >= cols_r);          // last column of the row
    c_wrap  = (c_plus2 >= CW1'(cols_r));  // two ahead runs off the row
    row_inc = row_r + RW'(1);
  end

  // word classification
  always_comb begin
    case (phase_r)
      PH_TOP:   hit = in_acc && (typ == REQ_TOP);
      PH_LEFT:  hit = in_acc && (typ == REQ_LEFT);
      PH_MID:   hit = in_acc && (typ == REQ_MID);
      PH_RIGHT: hit = in_acc && (typ == REQ_RIGHT);
      PH_BOT:   hit = in_acc && (typ == REQ_BOT);
      default:  hit = 1'b0;
    endcase
    samp = hit && (phase_r == PH_TOP || phase_r == PH_MID || phase_r == PH_BOT);
    emit = hit && ((phase_r == PH_MID && row_r != '0) || phase_r == PH_BOT);
  end

  // register clamp
  always_comb begin
    cfg_val32 = 32'(cfg_data);
    if (cfg_val32 < 32'd2) begin
      cols_clamp = CW'(2);
      rows_clamp = RW'(2);
    end else begin
      cols_clamp = (cfg_val32 > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cfg_val32);
      rows_clamp = (cfg_val32 > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_val32);
    end
  end

  // sequencing
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    edge0_nxt = edge0_r;
    edge1_nxt = edge1_r;
    edge2_nxt = edge2_r;

    if (hit) begin
      case (phase_r)
        PH_TOP: begin
          col_nxt = c_inc[AW-1:0];
          if (c_end) begin
            col_nxt   = '0;
            row_nxt   = '0;
            phase_nxt = PH_LEFT;
          end
        end
        PH_LEFT: begin
          edge2_nxt = smp;
          col_nxt   = '0;
          phase_nxt = PH_MID;
        end
        PH_MID: begin
          col_nxt = c_inc[AW-1:0];
          if (c_end) begin
            col_nxt   = '0;
            phase_nxt = PH_RIGHT;
          end
        end
        PH_RIGHT: begin
          edge0_nxt = edge2_r;
          edge1_nxt = smp;
          row_nxt   = row_inc;
          col_nxt   = '0;
          phase_nxt = (row_inc >= rows_r) ? PH_BOT : PH_LEFT;
        end
        PH_BOT: begin
          col_nxt = c_inc[AW-1:0];
          if (c_end) begin
            col_nxt   = '0;
            row_nxt   = '0;
            phase_nxt = PH_TOP;
          end
        end
        default: begin
          phase_nxt = PH_TOP;
        end
      endcase
    end

    if (cfg_wr) begin
      case (cfg_index)
        REG_GRID_COLS: cols_nxt = cols_clamp;
        REG_GRID_ROWS: rows_nxt = rows_clamp;
        default: begin
        end
      endcase
    end
  end

  // window reload after a size change: FETCH0 reads the current column,
  // FETCH1 moves it into the center cell and reads the next one
  always_comb begin
    if (cfg_wr) begin
      fst_nxt = ST_FETCH0;
    end else begin
      case (fst_r)
        ST_FETCH0: fst_nxt = ST_FETCH1;
        ST_FETCH1: fst_nxt = ST_RUN;
        ST_RUN:    fst_nxt = ST_RUN;
        default:   fst_nxt = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOP;
      fst_r   <= ST_RUN;
      col_r   <= '0;
      row_r   <= '0;
      cols_r  <= CW'(RST_COLS);
      rows_r  <= RW'(RST_ROWS);
    end else begin
      phase_r <= phase_nxt;
      fst_r   <= fst_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge0_r <= edge0_nxt;
    edge1_r <= edge1_nxt;
    edge2_r <= edge2_nxt;
  end

  // Line store read: the read register is the window's right column. It
  // holds column c+1 of the pending row (column 0 once the row is done),
  // so a sample at c reads two ahead, wrapping to the next row's start.
  always_comb begin
    rd_en   = samp || (fst_r == ST_FETCH0) || (fst_r == ST_FETCH1);
    w0_load = samp || (fst_r == ST_FETCH1);
    case (fst_r)
      ST_FETCH0: rd_addr = col_r;
      ST_FETCH1: rd_addr = c_end ? '0 : c_inc[AW-1:0];
      default: begin
        if (c_end) begin
          rd_addr = AW'(1);
        end else if (c_wrap) begin
          rd_addr = '0;
        end else begin
          rd_addr = c_plus2[AW-1:0];
        end
      end
    endcase
    // center moves up, new word becomes center
    wr_pair.above  = w_ctr.center;
    wr_pair.center = smp;
  end

  lap5_line #(
    .DEPTH(MAX_COLS)
  ) u_line (
    .clk     (clk),
    .wr_en   (samp),
    .wr_addr (col_r),
    .wr_data (wr_pair),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (w_right)
  );

  lap5_cell u_cell_ctr (
    .clk  (clk),
    .load (w0_load),
    .d_in (w_right),
    .q    (w_ctr)
  );

  lap5_cell u_cell_left (
    .clk  (clk),
    .load (samp),
    .d_in (w_ctr),
    .q    (w_left)
  );

  // taps; row edges stand in for neighbors off the grid
  always_comb begin
    opnd.up     = w_ctr.above;
    opnd.center = w_ctr.center;
    opnd.below  = smp;
    opnd.left   = (col_r == '0) ? edge0_r : w_left.center;
    opnd.right  = c_end ? edge1_r : w_right.center;
    opnd.row    = ROWIDX_W'(row_r - RW'(1));
    opnd.col    = COLIDX_W'(col_r);
    opnd.last   = (phase_r == PH_BOT) && c_end;
  end

  lap5_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (emit),
    .opnd      (opnd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (pst)
  );

  // checks
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
      (cfg_valid && cfg_ready) |=> in_stall)
    else $error("input taken during window reload");

  a_grid_end: assert property (@(posedge clk) disable iff (!rst_n)
      (emit && opnd.last) |=> (phase_r == PH_TOP && col_r == '0 && row_r == '0))
    else $error("grid did not restart after last cell");

  a_bot_row: assert property (@(posedge clk) disable iff (!rst_n)
      (phase_r == PH_BOT) |-> (row_r != '0))
    else $error("bottom row reached with no pending row");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
      (pst.s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input open while result pipe is full");

endmodule

/* verif/laplace_5point_stencil_tb.sv */
// ----------------------------------------------------------------------------
// laplace_5point_stencil_tb: self-checking bench for the 5-point stencil
// Streams complete framed grids (top row, edged interior rows, bottom row)
// with stray words of the wrong type mixed in, predicts every cell's
// Laplacian, row, column and last flag, and checks each result word in
// order. Grid sizes change only between grids, with the block idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplace_5point_stencil_tb;
  import lap5_pkg::*;

  localparam int GRID_MAX       = 1024;  // matches the block's MAX_COLS/MAX_ROWS
  localparam int RANDOM_WORDS   = 620;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam sample_t S_MIN = 16'sh8000;
  localparam sample_t S_MAX = 16'sh7fff;

  // value patterns for a grid
  localparam int PAT_RANDOM  = 0;
  localparam int PAT_PEAK_HI = 1;  // checkerboard giving the largest result
  localparam int PAT_PEAK_LO = 2;  // checkerboard giving the smallest result

  // --------------------------------------------------------------------------
  // Stencil predictor and queue of pending cell results
  // --------------------------------------------------------------------------
  class lap_scoreboard;
    typedef enum logic [2:0] {
      WAIT_TOP, WAIT_LEFT, WAIT_MID, WAIT_RIGHT, WAIT_BOT
    } frame_pos_e;

    sample_t    above_row [GRID_MAX];
    sample_t    center_row[GRID_MAX];
    sample_t    pend_left, pend_right, next_left;  // edges of pending/incoming row
    int         cols, rows, row_cnt, col_cnt;
    frame_pos_e pos;
    lap5_out_t  cells_due[$];
    int         mismatches;

    function new();
      cols       = GRID_MAX;
      rows       = GRID_MAX;
      row_cnt    = 0;
      col_cnt    = 0;
      pos        = WAIT_TOP;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      int n;
      n = int'(v);
      if (n < 2) n = 2;
      if (n > GRID_MAX) n = GRID_MAX;
      if (idx == REG_GRID_COLS) cols = n;
      else rows = n;
    endfunction

    // center moves up, new value becomes the center
    function void shift_col(int c, sample_t s);
      above_row[c]  = center_row[c];
      center_row[c] = s;
    endfunction

    // Laplacian of pending-row cell c; must run before shift_col(c)
    function void queue_cell(int c, sample_t below, int r, bit last);
      int        up, mid, lt, rt, sum;
      lap5_out_t e;
      up  = int'(above_row[c]);
      mid = int'(center_row[c]);
      lt  = (c == 0) ? int'(pend_left) : int'(above_row[c-1]);  // c-1 already shifted
      rt  = (c + 1 >= cols) ? int'(pend_right) : int'(center_row[c+1]);
      sum = up + int'(below) + lt + rt - 4 * mid;
      e.lap_value    = sum[LAP_BITS-1:0];
      e.out_row      = r[ROWIDX_W-1:0];
      e.out_col      = c[COLIDX_W-1:0];
      e.last_of_grid = last;
      cells_due.push_back(e);
    endfunction

    // words whose type doesn't fit the frame position are dropped
    function void note_input(lap5_in_t w);
      sample_t s;
      bit      last;
      s = w.sample_value;
      case (pos)
        WAIT_TOP: if (w.req_type == REQ_TOP) begin
          shift_col(col_cnt, s);
          col_cnt++;
          if (col_cnt >= cols) begin
            col_cnt = 0;
            row_cnt = 0;
            pos     = WAIT_LEFT;
          end
        end
        WAIT_LEFT: if (w.req_type == REQ_LEFT) begin
          next_left = s;
          col_cnt   = 0;
          pos       = WAIT_MID;
        end
        WAIT_MID: if (w.req_type == REQ_MID) begin
          if (row_cnt >= 1) queue_cell(col_cnt, s, row_cnt - 1, 1'b0);
          shift_col(col_cnt, s);
          col_cnt++;
          if (col_cnt >= cols) begin
            col_cnt = 0;
            pos     = WAIT_RIGHT;
          end
        end
        WAIT_RIGHT: if (w.req_type == REQ_RIGHT) begin
          pend_left  = next_left;
          pend_right = s;
          row_cnt++;
          col_cnt = 0;
          pos     = (row_cnt >= rows) ? WAIT_BOT : WAIT_LEFT;
        end
        default: if (w.req_type == REQ_BOT) begin
          last = (col_cnt + 1 >= cols);
          queue_cell(col_cnt, s, row_cnt - 1, last);
          shift_col(col_cnt, s);
          col_cnt++;
          if (last) begin
            col_cnt = 0;
            row_cnt = 0;
            pos     = WAIT_TOP;
          end
        end
      endcase
    endfunction

    function void report(string what, lap5_out_t want, lap5_out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH (%s) want lap=%0d row=%0d col=%0d last=%0b",
                 what, want.lap_value, want.out_row, want.out_col, want.last_of_grid,
                 " | got lap=%0d row=%0d col=%0d last=%0b",
                 got.lap_value, got.out_row, got.out_col, got.last_of_grid);
    endfunction

    function void check_result(lap5_out_t got);
      lap5_out_t want;
      if (cells_due.size() == 0) begin
        report("nothing pending", '0, got);
        return;
      end
      want = cells_due.pop_front();
      if (got.lap_value !== want.lap_value || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last_of_grid !== want.last_of_grid)
        report("field", want, got);
    endfunction

    function int pending_count();
      return cells_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals, DUT
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lap5_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lap5_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lap_scoreboard sb = new();
  bit            calm = 1'b0;      // set: neither side idles
  int            words_sent = 0;   // framed words only, strays not counted
  int            quiet_cycles = 0;

  always #4 clk = ~clk;

  laplace_5point_stencil uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ~26% idle cycles on either side unless in a calm stretch
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  // Result side: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= take_break();
  end

  // Result words are taken on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("laplace_5point_stencil: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All are entered and left on a falling edge.
  // --------------------------------------------------------------------------

  // Present one word and hold it until taken. in_valid is left high on exit
  // so back-to-back words need no low/high pair in one step; park_input()
  // drops it once the stream stops.
  task automatic send_word(input lap5_in_t w);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every pending cell, then wait out SETTLE_CYCLES so the block is idle
  task automatic settle();
    park_input();
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random sample, biased toward the extremes, zero and -1
  function automatic sample_t rand_sample();
    case ($urandom_range(15))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return '0;
      3:       return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic sample_t grid_value(int pat, bit is_bound, int i, int j);
    bit even;
    even = ((i + j) % 2) == 0;
    case (pat)
      PAT_PEAK_HI: return is_bound ? S_MAX : (even ? S_MIN : S_MAX);
      PAT_PEAK_LO: return is_bound ? S_MIN : (even ? S_MAX : S_MIN);
      default:     return rand_sample();
    endcase
  endfunction

  // One framed word, sometimes preceded by a stray word of a wrong type
  task automatic send_item(input logic [TYPE_W-1:0] kind, input sample_t v,
                           input int stray_pct);
    lap5_in_t w;
    if ($urandom_range(99) < stray_pct) begin
      w.req_type = kind;
      while (w.req_type == kind) w.req_type = TYPE_W'($urandom_range(7));
      w.sample_value = rand_sample();
      send_word(w);
    end
    w.req_type     = kind;
    w.sample_value = v;
    send_word(w);
    words_sent++;
  endtask

  // Whole grid in stream order: top row, edged interior rows, bottom row
  task automatic run_grid(input int cols, input int rows, input int pat,
                          input int stray_pct);
    for (int j = 0; j < cols; j++)
      send_item(REQ_TOP, grid_value(pat, 1'b1, 0, j), stray_pct);
    for (int i = 0; i < rows; i++) begin
      send_item(REQ_LEFT, grid_value(pat, 1'b1, i, 0), stray_pct);
      for (int j = 0; j < cols; j++)
        send_item(REQ_MID, grid_value(pat, 1'b0, i, j), stray_pct);
      send_item(REQ_RIGHT, grid_value(pat, 1'b1, i, 0), stray_pct);
    end
    for (int j = 0; j < cols; j++)
      send_item(REQ_BOT, grid_value(pat, 1'b1, 0, j), stray_pct);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    lap5_in_t w;
    int       rand_start, c, r, k;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size is 1024x1024 (a million words): shrink before any data.
    write_size(REG_GRID_COLS, 11'd2);
    write_size(REG_GRID_ROWS, 11'd2);

    // Every wrong type while waiting for the top row, 5..7 included
    for (int t = 1; t < 8; t++) begin
      w.req_type     = t[TYPE_W-1:0];
      w.sample_value = rand_sample();
      send_word(w);
    end

    // 2x2 checkerboards: +262140 and -262140 results, corner cells,
    // then a second grid right after the first finishes
    run_grid(2, 2, PAT_PEAK_HI, 0);
    settle();
    calm = 1'b1;
    run_grid(2, 2, PAT_PEAK_LO, 0);
    settle();
    calm = 1'b0;

    // Out-of-range writes that clamp, then a wider grid
    write_size(REG_GRID_COLS, 11'd0);      // acts as 2
    write_size(REG_GRID_ROWS, 11'd1);      // acts as 2
    run_grid(2, 2, PAT_RANDOM, 2);
    settle();
    write_size(REG_GRID_COLS, 11'd2047);   // acts as 1024
    write_size(REG_GRID_ROWS, 11'd2047);   // acts as 1024
    write_size(REG_GRID_COLS, 11'd60);
    write_size(REG_GRID_ROWS, 11'd2);
    run_grid(60, 2, PAT_RANDOM, 2);
    settle();

    // Random small grids with stray words; one long calm stretch
    rand_start = words_sent;
    while (words_sent < rand_start + RANDOM_WORDS) begin
      c = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(2, 8);
      r = $urandom_range(2, 6);
      k = words_sent - rand_start;
      calm = (k >= 200) && (k < 380);
      if (c == 2 && $urandom_range(1))
        write_size(REG_GRID_COLS, CFG_DATA_W'($urandom_range(1)));
      else write_size(REG_GRID_COLS, c[CFG_DATA_W-1:0]);
      if (r == 2 && $urandom_range(1))
        write_size(REG_GRID_ROWS, CFG_DATA_W'($urandom_range(1)));
      else write_size(REG_GRID_ROWS, r[CFG_DATA_W-1:0]);
      run_grid(c, r, PAT_RANDOM, 6);
      settle();
    end

    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("laplace_5point_stencil: match");
    else
      $display("laplace_5point_stencil: mismatch");
    $finish;
  end

endmodule
